// ===== rtl/core/wspd_pkg.sv =====
package wspd_pkg;

	localparam int SPD_W   = 24;
	localparam int ERR_W   = SPD_W + 1;
	localparam int DER_W   = ERR_W + 1;
	localparam int SUM_W   = 40;
	localparam int GAIN_W  = 24;
	localparam int FF_W    = 8;
	localparam int DUTY_W  = 8;
	localparam int IDX_W   = 8;
	localparam int CDATA_W = 24;
	localparam int FRAC_W  = 24;

	// integral product is split into a low unsigned and a high signed slice
	localparam int ILO_W   = SUM_W / 2;
	localparam int IHI_W   = SUM_W - ILO_W;
	localparam int PILO_W  = GAIN_W + 1 + ILO_W + 1;
	localparam int PIHI_W  = GAIN_W + 1 + IHI_W;
	localparam int PP_W    = GAIN_W + 1 + ERR_W;
	localparam int PD_W    = GAIN_W + 1 + DER_W;
	localparam int BIG_W   = GAIN_W + SUM_W + 1;
	localparam int SMALL_W = PD_W + 2;
	localparam int TOT_W   = BIG_W + 1;

	localparam logic [GAIN_W-1:0] GAIN_P_RST = GAIN_W'(16384);
	localparam logic [GAIN_W-1:0] GAIN_I_RST = GAIN_W'(3277);
	localparam logic [GAIN_W-1:0] GAIN_D_RST = '0;
	localparam logic [FF_W-1:0]   FF_RST     = FF_W'(165);

	typedef enum logic [IDX_W-1:0] {
		REG_GAIN_P = 8'd0,
		REG_GAIN_I = 8'd1,
		REG_GAIN_D = 8'd2,
		REG_FF     = 8'd3
	} reg_idx_t;

	typedef struct packed {
		logic adv;
		logic vld;
	} stage_ctl_t;

	typedef struct packed {
		logic pos;
		logic neg;
	} dir_t;

endpackage

// ===== rtl/core/wspd_if.sv =====
interface wspd_req_if
	import wspd_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic signed [SPD_W-1:0]  target_speed;
	logic signed [SPD_W-1:0]  measured_speed;

	modport source (output valid, output target_speed, output measured_speed, input ready);
	modport sink   (input valid, input target_speed, input measured_speed, output ready);
endinterface

interface wspd_rsp_if
	import wspd_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [DUTY_W-1:0] pin_a_duty;
	logic [DUTY_W-1:0] pin_b_duty;
	logic              duty_clamped;

	modport source (output valid, output pin_a_duty, output pin_b_duty, output duty_clamped,
		input ready);
	modport sink   (input valid, input pin_a_duty, input pin_b_duty, input duty_clamped,
		output ready);
endinterface

interface wspd_cfg_if
	import wspd_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [IDX_W-1:0]   idx;
	logic [CDATA_W-1:0] data;

	modport source (output valid, output idx, output data, input ready);
	modport sink   (input valid, input idx, input data, output ready);
endinterface

// ===== rtl/core/wspd_integ.sv =====
module wspd_integ
	import wspd_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  stage_ctl_t               ctl,
	input  logic signed [SPD_W-1:0]  target_s1,
	input  logic signed [SPD_W-1:0]  measured_s1,
	output logic signed [ERR_W-1:0]  err_s2,
	output logic signed [DER_W-1:0]  der_s2,
	output logic signed [SUM_W-1:0]  sum_s2,
	output dir_t                     dir_s2
);

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	logic signed [SUM_W-1:0] sum_q;
	logic signed [ERR_W-1:0] prev_err_q;
	logic signed [ERR_W-1:0] err;
	logic signed [DER_W-1:0] der;
	logic signed [SUM_W:0]   sum_raw;
	logic signed [SUM_W-1:0] sum_sat;
	dir_t                    dir;

	always_comb begin
		err     = ERR_W'(target_s1) - ERR_W'(measured_s1);
		der     = DER_W'(err) - DER_W'(prev_err_q);
		sum_raw = (SUM_W+1)'(sum_q) + (SUM_W+1)'(err);
		if (sum_raw[SUM_W] != sum_raw[SUM_W-1]) begin
			sum_sat = sum_raw[SUM_W] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_sat = sum_raw[SUM_W-1:0];
		end
		dir.neg = target_s1[SPD_W-1];
		dir.pos = !target_s1[SPD_W-1] && (target_s1 != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q      <= '0;
			prev_err_q <= '0;
		end else if (ctl.adv && ctl.vld) begin
			sum_q      <= sum_sat;
			prev_err_q <= err;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			err_s2 <= err;
			der_s2 <= der;
			sum_s2 <= sum_sat;
			dir_s2 <= dir;
		end
	end

endmodule

// ===== rtl/core/wspd_mac.sv =====
module wspd_mac
	import wspd_pkg::*;
(
	input  logic                       clk,
	input  logic                       adv,
	input  logic        [GAIN_W-1:0]   gain_p,
	input  logic        [GAIN_W-1:0]   gain_i,
	input  logic        [GAIN_W-1:0]   gain_d,
	input  logic        [FF_W-1:0]     feed_forward,
	input  logic signed [ERR_W-1:0]    err_s2,
	input  logic signed [DER_W-1:0]    der_s2,
	input  logic signed [SUM_W-1:0]    sum_s2,
	output logic signed [BIG_W-1:0]    big_s4,
	output logic signed [SMALL_W-1:0]  small_s4
);

	logic signed [PILO_W-1:0]  pilo_s3;
	logic signed [PIHI_W-1:0]  pihi_s3;
	logic signed [PP_W-1:0]    pp_s3;
	logic signed [PD_W-1:0]    pd_s3;
	logic signed [GAIN_W:0]    gp_sx;
	logic signed [GAIN_W:0]    gi_sx;
	logic signed [GAIN_W:0]    gd_sx;
	logic signed [ILO_W:0]     slo_sx;
	logic signed [IHI_W-1:0]   shi_sx;
	logic signed [SMALL_W-1:0] ff_sx;

	always_comb begin
		gp_sx  = $signed({1'b0, gain_p});
		gi_sx  = $signed({1'b0, gain_i});
		gd_sx  = $signed({1'b0, gain_d});
		slo_sx = $signed({1'b0, sum_s2[ILO_W-1:0]});
		shi_sx = $signed(sum_s2[SUM_W-1:ILO_W]);
		ff_sx  = $signed({{(SMALL_W-FF_W-FRAC_W){1'b0}}, feed_forward, {FRAC_W{1'b0}}});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pilo_s3 <= gi_sx * slo_sx;
			pihi_s3 <= gi_sx * shi_sx;
			pp_s3   <= gp_sx * err_s2;
			pd_s3   <= gd_sx * der_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			big_s4   <= (BIG_W'(pihi_s3) <<< ILO_W) + BIG_W'(pilo_s3);
			small_s4 <= SMALL_W'(pp_s3) + SMALL_W'(pd_s3) + ff_sx;
		end
	end

endmodule

// ===== rtl/core/wspd_drive.sv =====
module wspd_drive
	import wspd_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  stage_ctl_t                ctl,
	input  logic signed [BIG_W-1:0]   big_s4,
	input  logic signed [SMALL_W-1:0] small_s4,
	input  dir_t                      dir_s4,
	output logic [DUTY_W-1:0]         pin_a_q,
	output logic [DUTY_W-1:0]         pin_b_q,
	output logic                      clamp_q
);

	logic signed [TOT_W-1:0] total;
	logic                    neg;
	logic                    over;
	logic                    frac_only;
	logic [DUTY_W-1:0]       duty;
	logic                    clamped;

	always_comb begin
		total     = TOT_W'(big_s4) + TOT_W'(small_s4);
		neg       = total[TOT_W-1];
		over      = |total[TOT_W-2:FRAC_W+DUTY_W];
		// negative drive above -1 truncates to zero, no clamp
		frac_only = (&total[TOT_W-1:FRAC_W]) && (|total[FRAC_W-1:0]);
		if (neg) begin
			duty    = '0;
			clamped = !frac_only;
		end else if (over) begin
			duty    = '1;
			clamped = 1'b1;
		end else begin
			duty    = total[FRAC_W+DUTY_W-1:FRAC_W];
			clamped = 1'b0;
		end
	end

	// pin registers double as the held levels for a zero target
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_a_q <= '0;
			pin_b_q <= '0;
			clamp_q <= 1'b0;
		end else if (ctl.adv && ctl.vld) begin
			clamp_q <= clamped;
			if (dir_s4.pos) begin
				pin_a_q <= '0;
				pin_b_q <= duty;
			end else if (dir_s4.neg) begin
				pin_a_q <= duty;
				pin_b_q <= '0;
			end
		end
	end

endmodule

// ===== rtl/core/wheel_speed_pid_hbridge_drive.sv =====
// channel | dir | fields                            | notes
// req     | in  | target_speed, measured_speed      | Q16.8 RPM, signed
// rsp     | out | pin_a_duty, pin_b_duty, duty_clamped | one item per req item
// cfg     | in  | idx, data                         | always ready; 0 gain_p .. 3 feed_forward
//
// Five register stages: input, integral, products, partial sums, output.
// One item per cycle is accepted when rsp is not stalled.
// A stalled rsp freezes every stage, and req.ready drops with it.
// Reset clears the integral, last error, pin levels and valid bits;
// gains return to their defaults.
module wheel_speed_pid_hbridge_drive
	import wspd_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	wspd_req_if.sink        req,
	wspd_rsp_if.source      rsp,
	wspd_cfg_if.sink        cfg
);

	logic [GAIN_W-1:0] gain_p_q;
	logic [GAIN_W-1:0] gain_i_q;
	logic [GAIN_W-1:0] gain_d_q;
	logic [FF_W-1:0]   ff_q;

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_q;

	logic signed [SPD_W-1:0]   target_s1;
	logic signed [SPD_W-1:0]   measured_s1;
	logic signed [ERR_W-1:0]   err_s2;
	logic signed [DER_W-1:0]   der_s2;
	logic signed [SUM_W-1:0]   sum_s2;
	logic signed [BIG_W-1:0]   big_s4;
	logic signed [SMALL_W-1:0] small_s4;
	dir_t                      dir_s2, dir_s3, dir_s4;
	stage_ctl_t                ctl_integ, ctl_drive;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= GAIN_P_RST;
			gain_i_q <= GAIN_I_RST;
			gain_d_q <= GAIN_D_RST;
			ff_q     <= FF_RST;
		end else if (cfg.valid) begin
			unique case (cfg.idx)
				REG_GAIN_P: gain_p_q <= cfg.data;
				REG_GAIN_I: gain_i_q <= cfg.data;
				REG_GAIN_D: gain_d_q <= cfg.data;
				REG_FF:     ff_q     <= cfg.data[FF_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.ready = 1'b1;

	assign adv       = !v_q || rsp.ready;
	assign req.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_q  <= 1'b0;
		end else if (adv) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_q  <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			target_s1   <= req.target_speed;
			measured_s1 <= req.measured_speed;
			dir_s3      <= dir_s2;
			dir_s4      <= dir_s3;
		end
	end

	assign ctl_integ = '{adv: adv, vld: v_s1};
	assign ctl_drive = '{adv: adv, vld: v_s4};

	wspd_integ u_integ (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl_integ),
		.target_s1   (target_s1),
		.measured_s1 (measured_s1),
		.err_s2      (err_s2),
		.der_s2      (der_s2),
		.sum_s2      (sum_s2),
		.dir_s2      (dir_s2)
	);

	wspd_mac u_mac (
		.clk          (clk),
		.adv          (adv),
		.gain_p       (gain_p_q),
		.gain_i       (gain_i_q),
		.gain_d       (gain_d_q),
		.feed_forward (ff_q),
		.err_s2       (err_s2),
		.der_s2       (der_s2),
		.sum_s2       (sum_s2),
		.big_s4       (big_s4),
		.small_s4     (small_s4)
	);

	wspd_drive u_drive (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl_drive),
		.big_s4   (big_s4),
		.small_s4 (small_s4),
		.dir_s4   (dir_s4),
		.pin_a_q  (rsp.pin_a_duty),
		.pin_b_q  (rsp.pin_b_duty),
		.clamp_q  (rsp.duty_clamped)
	);

	assign rsp.valid = v_q;

endmodule

// ===== rtl/core/wspd_checker.sv =====
module wspd_checker
	import wspd_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [DUTY_W-1:0] pin_a_duty,
	input logic [DUTY_W-1:0] pin_b_duty,
	input logic              duty_clamped
);

	// no result while in reset
	a_rst_idle: assert property (@(posedge clk) !arst_n |-> !rsp_valid)
		else $error("rsp valid during reset");

	// bridge never drives both pins
	a_one_pin: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (pin_a_duty == '0 || pin_b_duty == '0))
		else $error("both bridge pins driven");

	// pipeline only stalls on a held result
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!rsp_valid || rsp_ready) |-> req_ready)
		else $error("req stalled with rsp free");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(pin_a_duty)
			&& $stable(pin_b_duty) && $stable(duty_clamped))
		else $error("stalled rsp item changed");

endmodule

bind wheel_speed_pid_hbridge_drive wspd_checker u_wspd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.pin_a_duty   (rsp.pin_a_duty),
	.pin_b_duty   (rsp.pin_b_duty),
	.duty_clamped (rsp.duty_clamped)
);
